>>> sv/pct_pkg.sv
// Package: shared types, opcodes and constants of the proximity claim table.
`default_nettype none
package pct_pkg;

  localparam int KNOWN_DEPTH_DEF   = 16;
  localparam int PENDING_DEPTH_DEF = 8;

  localparam int          SEQ_W    = 24;
  localparam logic [23:0] SEQ_MASK = 24'hFF_FFFF;
  localparam int          ID_SHIFT = 24;

  localparam logic [3:0] OP_CLAIM   = 4'd0;
  localparam logic [3:0] OP_RESOLVE = 4'd1;
  localparam logic [3:0] OP_WIN     = 4'd2;
  localparam logic [3:0] OP_DONE    = 4'd3;
  localparam logic [3:0] OP_RX_CLM  = 4'd4;
  localparam logic [3:0] OP_RX_WIN  = 4'd5;
  localparam logic [3:0] OP_RX_DONE = 4'd6;
  localparam logic [3:0] OP_QUERY   = 4'd7;
  localparam logic [3:0] OP_CLEAR   = 4'd8;

  localparam logic [1:0] CFG_OWN_ID  = 2'd0;
  localparam logic [1:0] CFG_CLAIM_R = 2'd1;
  localparam logic [1:0] CFG_EXCL_R  = 2'd2;

  localparam logic [7:0]  OWN_ID_RST  = 8'd1;
  localparam logic [14:0] CLAIM_R_RST = 15'd500;
  localparam logic [14:0] EXCL_R_RST  = 15'd1000;

  localparam int CNT_OUT_W = 7;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         owner;
    logic               done;
    logic               valid;
  } pct_site_t;

  typedef struct packed {
    logic [31:0]        id;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         my_conf;
    logic [7:0]         best_conf;
    logic [7:0]         best_id;
    logic               valid;
  } pct_pend_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         confidence;
    logic [7:0]         sender_id;
    logic [31:0]        claim_tag;
  } pct_in_t;

  typedef struct packed {
    logic [31:0] new_claim_id;
    logic        won;
    logic        stored;
    logic        already_claimed;
    logic        in_exclusion;
    logic [6:0]  known_count;
  } pct_out_t;

endpackage
`default_nettype wire

>>> sv/pct_cell.sv
// Ring cell: one table entry, shifts to its neighbor, indexed write and clear.
`default_nettype none
module pct_cell #(
  parameter type T   = logic,
  parameter int  IW  = 1,
  parameter int  IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr,
  input  wire logic          shift_en,
  input  wire T              shift_in,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_idx,
  input  wire T              wr_data,
  output T                   q
);

  T ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      ent_r <= '0;
    end else if (wr_en && (wr_idx == IW'(IDX))) begin
      ent_r <= wr_data;
    end else if (shift_en) begin
      ent_r <= shift_in;
    end
  end

  assign q = ent_r;

endmodule
`default_nettype wire

>>> sv/pct_near.sv
// Nearness unit: registered squares, then dx^2+dy^2 <= r^2.
`default_nettype none
module pct_near (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic signed [15:0] a_x,
  input  wire logic signed [15:0] a_y,
  input  wire logic signed [15:0] b_x,
  input  wire logic signed [15:0] b_y,
  input  wire logic [29:0]        r2,
  output logic                    near
);

  logic signed [16:0] dx, dy;
  logic signed [33:0] px, py;
  logic [33:0]        sqx_r, sqy_r;
  logic [34:0]        sum;

  assign dx  = 17'(a_x) - 17'(b_x);
  assign dy  = 17'(a_y) - 17'(b_y);
  assign px  = dx * dx;
  assign py  = dy * dy;

  always_ff @(posedge clk) begin
    if (load) begin
      sqx_r <= px;
      sqy_r <= py;
    end
  end

  assign sum  = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign near = (sum <= {5'b0, r2});

endmodule
`default_nettype wire

>>> sv/proximity_claim_table_top.sv
// Top level: sequencer over a ring of known-site cells and a ring of pending cells.
//
//  channel | direction | handshake               | payload
//  in_     | input     | in_valid / in_ready     | in_data  (pct_in_t)
//  out_    | output    | out_valid / out_ready   | out_data (pct_out_t)
//  cfg_    | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Each request rotates both rings one entry per step (square, then decide) past
// the shared nearness units, until the deeper ring has come full circle.
// Reset is synchronous and clears both tables at once; no clearing pass.
// A new request is taken while a finished result waits in the output register;
// the finish step stalls only until that register is free.
`default_nettype none
module proximity_claim_table_top #(
  parameter int KNOWN_DEPTH   = pct_pkg::KNOWN_DEPTH_DEF,
  parameter int PENDING_DEPTH = pct_pkg::PENDING_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pct_pkg::pct_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pct_pkg::pct_out_t     out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);
  import pct_pkg::*;

  localparam int MAXD = (KNOWN_DEPTH > PENDING_DEPTH) ? KNOWN_DEPTH : PENDING_DEPTH;
  localparam int KIW  = (KNOWN_DEPTH > 1) ? $clog2(KNOWN_DEPTH) : 1;
  localparam int PIW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int SW   = $clog2(MAXD + 1);
  localparam int CW   = $clog2(KNOWN_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SQ, S_DEC, S_FIN} state_t;

  state_t          state_r, state_nxt;
  pct_in_t         req_r, req_nxt;
  logic [29:0]     r2c_r, r2c_nxt, r2e_r, r2e_nxt;
  logic [SW-1:0]   step_r, step_nxt;
  logic            kn_found_r, kn_found_nxt, ki_found_r, ki_found_nxt;
  logic [KIW-1:0]  kn_idx_r, kn_idx_nxt, ki_idx_r, ki_idx_nxt;
  pct_site_t       kn_ent_r, kn_ent_nxt;
  logic            claimed_r, claimed_nxt, excl_r, excl_nxt;
  logic            pi_found_r, pi_found_nxt, res_found_r, res_found_nxt;
  logic [PIW-1:0]  pi_idx_r, pi_idx_nxt;
  logic            won_r, won_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  pct_out_t        out_r, out_nxt;
  logic [7:0]      own_id_r;
  logic [14:0]     claim_r_r, excl_r_r;

  pct_site_t       kq [KNOWN_DEPTH];
  pct_pend_t       pq [PENDING_DEPTH];
  pct_pend_t       p_mod, p_wr_data;
  pct_site_t       k_wr_data, k_new;
  logic            k_wr_en, p_wr_en, tbl_clr, k_shift, p_shift;
  logic            near_kc, near_ke, near_pc, own_pkt, sq_load;

  assign sq_load = (state_r == S_SQ);
  assign k_shift = (state_r == S_DEC) && (step_r < SW'(KNOWN_DEPTH));
  assign p_shift = (state_r == S_DEC) && (step_r < SW'(PENDING_DEPTH));
  assign own_pkt = (req_r.sender_id == own_id_r);

  pct_near u_near_kc (.clk(clk), .load(sq_load), .a_x(req_r.pos_x), .a_y(req_r.pos_y),
                      .b_x(kq[0].x), .b_y(kq[0].y), .r2(r2c_r), .near(near_kc));
  pct_near u_near_ke (.clk(clk), .load(sq_load), .a_x(req_r.pos_x), .a_y(req_r.pos_y),
                      .b_x(kq[0].x), .b_y(kq[0].y), .r2(r2e_r), .near(near_ke));
  pct_near u_near_pc (.clk(clk), .load(sq_load), .a_x(req_r.pos_x), .a_y(req_r.pos_y),
                      .b_x(pq[0].x), .b_y(pq[0].y), .r2(r2c_r), .near(near_pc));

  for (genvar i = 0; i < KNOWN_DEPTH; i++) begin : g_known
    pct_site_t sin;
    if (i == KNOWN_DEPTH - 1) begin : g_tail
      assign sin = kq[0];
    end else begin : g_mid
      assign sin = kq[i+1];
    end
    pct_cell #(.T(pct_site_t), .IW(KIW), .IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .clr(tbl_clr), .shift_en(k_shift), .shift_in(sin),
      .wr_en(k_wr_en), .wr_idx(kn_found_r ? kn_idx_r : ki_idx_r), .wr_data(k_wr_data),
      .q(kq[i]));
  end

  for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_pend
    pct_pend_t sin;
    if (i == PENDING_DEPTH - 1) begin : g_tail
      assign sin = p_mod;
    end else begin : g_mid
      assign sin = pq[i+1];
    end
    pct_cell #(.T(pct_pend_t), .IW(PIW), .IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .clr(tbl_clr), .shift_en(p_shift), .shift_in(sin),
      .wr_en(p_wr_en), .wr_idx(pi_idx_r), .wr_data(p_wr_data), .q(pq[i]));
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    r2c_nxt       = r2c_r;
    r2e_nxt       = r2e_r;
    step_nxt      = step_r;
    kn_found_nxt  = kn_found_r;
    ki_found_nxt  = ki_found_r;
    kn_idx_nxt    = kn_idx_r;
    ki_idx_nxt    = ki_idx_r;
    kn_ent_nxt    = kn_ent_r;
    claimed_nxt   = claimed_r;
    excl_nxt      = excl_r;
    pi_found_nxt  = pi_found_r;
    pi_idx_nxt    = pi_idx_r;
    res_found_nxt = res_found_r;
    won_nxt       = won_r;
    seq_nxt       = seq_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    p_mod         = pq[0];
    k_wr_en       = 1'b0;
    p_wr_en       = 1'b0;
    tbl_clr       = 1'b0;
    k_new         = kn_ent_r;
    k_wr_data     = kn_ent_r;
    p_wr_data     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt       = in_data;
          r2c_nxt       = 30'(claim_r_r) * 30'(claim_r_r);
          r2e_nxt       = 30'(excl_r_r) * 30'(excl_r_r);
          step_nxt      = '0;
          kn_found_nxt  = 1'b0;
          ki_found_nxt  = 1'b0;
          claimed_nxt   = 1'b0;
          excl_nxt      = 1'b0;
          pi_found_nxt  = 1'b0;
          res_found_nxt = 1'b0;
          won_nxt       = 1'b0;
          state_nxt     = S_SQ;
        end
      end
      S_SQ: state_nxt = S_DEC;
      S_DEC: begin
        if (k_shift) begin
          if (kq[0].valid && near_kc && !kn_found_r) begin
            kn_found_nxt = 1'b1;
            kn_idx_nxt   = step_r[KIW-1:0];
            kn_ent_nxt   = kq[0];
          end
          if (!kq[0].valid && !ki_found_r) begin
            ki_found_nxt = 1'b1;
            ki_idx_nxt   = step_r[KIW-1:0];
          end
          claimed_nxt = claimed_r || (kq[0].valid && near_kc);
          excl_nxt    = excl_r || (kq[0].valid && near_ke);
        end
        if (p_shift) begin
          if (!pq[0].valid && !pi_found_r) begin
            pi_found_nxt = 1'b1;
            pi_idx_nxt   = step_r[PIW-1:0];
          end
          case (req_r.opcode)
            OP_RESOLVE: begin
              if (req_r.claim_tag != '0 && pq[0].valid && pq[0].id == req_r.claim_tag
                  && !res_found_r) begin
                res_found_nxt = 1'b1;
                won_nxt       = (pq[0].best_conf < pq[0].my_conf) ||
                                (pq[0].best_conf == pq[0].my_conf &&
                                 own_id_r <= pq[0].best_id);
                p_mod.valid   = 1'b0;
              end
            end
            OP_RX_CLM: begin
              if (!own_pkt && pq[0].valid && near_pc) begin
                if (req_r.confidence > pq[0].best_conf) begin
                  p_mod.best_conf = req_r.confidence;
                  p_mod.best_id   = req_r.sender_id;
                end else if (req_r.confidence == pq[0].best_conf &&
                             req_r.sender_id < pq[0].best_id) begin
                  p_mod.best_id = req_r.sender_id;
                end
              end
            end
            OP_RX_WIN, OP_RX_DONE: begin
              if (!own_pkt && pq[0].valid && near_pc) begin
                p_mod.valid = 1'b0;
              end
            end
            default: ;
          endcase
        end
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(MAXD - 1)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt = '0;
          case (req_r.opcode)
            OP_CLAIM: begin
              if (pi_found_r) begin
                seq_nxt              = (seq_r + 1'b1) & SEQ_MASK;
                out_nxt.new_claim_id = (32'(own_id_r) << ID_SHIFT) | 32'(seq_nxt);
                p_wr_en              = 1'b1;
                p_wr_data.id         = out_nxt.new_claim_id;
                p_wr_data.x          = req_r.pos_x;
                p_wr_data.y          = req_r.pos_y;
                p_wr_data.my_conf    = req_r.confidence;
                p_wr_data.best_conf  = req_r.confidence;
                p_wr_data.best_id    = own_id_r;
                p_wr_data.valid      = 1'b1;
              end
            end
            OP_RESOLVE: out_nxt.won = won_r;
            OP_WIN, OP_DONE, OP_RX_WIN, OP_RX_DONE: begin
              if (!(req_r.opcode inside {OP_RX_WIN, OP_RX_DONE}) || !own_pkt) begin
                if (kn_found_r) begin
                  k_new.owner = (req_r.opcode inside {OP_WIN, OP_DONE}) ?
                                own_id_r : req_r.sender_id;
                  k_new.done  = kn_ent_r.done ||
                                (req_r.opcode inside {OP_DONE, OP_RX_DONE});
                  k_wr_en        = 1'b1;
                  out_nxt.stored = 1'b1;
                end else if (ki_found_r) begin
                  k_new.x     = req_r.pos_x;
                  k_new.y     = req_r.pos_y;
                  k_new.owner = (req_r.opcode inside {OP_WIN, OP_DONE}) ?
                                own_id_r : req_r.sender_id;
                  k_new.done  = (req_r.opcode inside {OP_DONE, OP_RX_DONE});
                  k_new.valid = 1'b1;
                  k_wr_en        = 1'b1;
                  out_nxt.stored = 1'b1;
                  cnt_nxt        = cnt_r + 1'b1;
                end
                k_wr_data = k_new;
              end
            end
            OP_QUERY: begin
              out_nxt.already_claimed = claimed_r;
              out_nxt.in_exclusion    = excl_r;
            end
            OP_CLEAR: begin
              tbl_clr = 1'b1;
              cnt_nxt = '0;
            end
            default: ;
          endcase
          out_nxt.known_count = CNT_OUT_W'(cnt_nxt);
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seq_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      own_id_r    <= OWN_ID_RST;
      claim_r_r   <= CLAIM_R_RST;
      excl_r_r    <= EXCL_R_RST;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_OWN_ID:  own_id_r  <= cfg_data[7:0];
          CFG_CLAIM_R: claim_r_r <= cfg_data[14:0];
          CFG_EXCL_R:  excl_r_r  <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
    req_r       <= req_nxt;
    r2c_r       <= r2c_nxt;
    r2e_r       <= r2e_nxt;
    step_r      <= step_nxt;
    kn_found_r  <= kn_found_nxt;
    ki_found_r  <= ki_found_nxt;
    kn_idx_r    <= kn_idx_nxt;
    ki_idx_r    <= ki_idx_nxt;
    kn_ent_r    <= kn_ent_nxt;
    claimed_r   <= claimed_nxt;
    excl_r      <= excl_nxt;
    pi_found_r  <= pi_found_nxt;
    pi_idx_r    <= pi_idx_nxt;
    res_found_r <= res_found_nxt;
    won_r       <= won_nxt;
    out_r       <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

>>> sv/pct_checker.sv
// Port checker for the proximity claim table, bound to the top level.
`default_nettype none
module pct_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire pct_pkg::pct_out_t out_data
);
  import pct_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.known_count <= 7'(KNOWN_DEPTH_DEF))
    else $error("known count beyond table depth");

  a_claim_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.new_claim_id != '0 |->
      !out_data.won && !out_data.stored && !out_data.already_claimed)
    else $error("claim result mixed with other results");

endmodule

bind proximity_claim_table_top pct_checker u_pct_checker (.*);
`default_nettype wire

>>> dv/tb_top.sv
// Testbench for proximity_claim_table_top: self-checking random and directed regression.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pct_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  pct_in_t in_data;
  pct_out_t out_data;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  proximity_claim_table_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted block state
  pct_site_t sites[KNOWN_DEPTH_DEF];
  pct_pend_t claims[PENDING_DEPTH_DEF];
  logic [23:0] seq_q;
  logic [7:0] node_id;
  logic [14:0] claim_r, excl_r;

  pct_out_t expected_q[$];
  int mismatches;
  int hold_left;
  bit no_gap;
  logic signed [15:0] cx[6], cy[6];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) if (hold_left > 0) hold_left <= hold_left - 1;

  function automatic bit is_near(logic signed [15:0] ax, logic signed [15:0] ay,
                                 logic signed [15:0] bx, logic signed [15:0] by,
                                 logic [14:0] r);
    longint dx, dy, rr;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    rr = longint'(r);
    return dx * dx + dy * dy <= rr * rr;
  endfunction

  function automatic int site_near(logic signed [15:0] x, logic signed [15:0] y,
                                   logic [14:0] r);
    for (int i = 0; i < KNOWN_DEPTH_DEF; i++)
      if (sites[i].valid && is_near(x, y, sites[i].x, sites[i].y, r)) return i;
    return -1;
  endfunction

  function automatic bit register_site(logic signed [15:0] x, logic signed [15:0] y,
                                       logic [7:0] owner, bit done);
    int i;
    i = site_near(x, y, claim_r);
    if (i >= 0) begin
      sites[i].owner = owner;
      if (done) sites[i].done = 1'b1;
      return 1;
    end
    for (i = 0; i < KNOWN_DEPTH_DEF; i++)
      if (!sites[i].valid) begin
        sites[i] = '{x: x, y: y, owner: owner, done: done, valid: 1'b1};
        return 1;
      end
    return 0;
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < KNOWN_DEPTH_DEF; i++) sites[i] = '0;
    for (int i = 0; i < PENDING_DEPTH_DEF; i++) claims[i] = '0;
  endfunction

  function automatic pct_out_t claim_table_step(pct_in_t d);
    pct_out_t r;
    int i;
    bit own_pkt;
    r = '0;
    own_pkt = (d.sender_id == node_id);
    case (d.opcode)
      OP_CLAIM: begin
        for (i = 0; i < PENDING_DEPTH_DEF; i++) if (!claims[i].valid) break;
        if (i < PENDING_DEPTH_DEF) begin
          seq_q = seq_q + 1;
          r.new_claim_id = {node_id, seq_q};
          claims[i] = '{id: r.new_claim_id, x: d.pos_x, y: d.pos_y, my_conf: d.confidence,
                        best_conf: d.confidence, best_id: node_id, valid: 1'b1};
        end
      end
      OP_RESOLVE: if (d.claim_tag != 0) begin
        for (i = 0; i < PENDING_DEPTH_DEF; i++)
          if (claims[i].valid && claims[i].id == d.claim_tag) begin
            if (claims[i].best_conf > claims[i].my_conf) r.won = 0;
            else if (claims[i].best_conf == claims[i].my_conf)
              r.won = (node_id <= claims[i].best_id);
            else r.won = 1;
            claims[i].valid = 1'b0;
            break;
          end
      end
      OP_WIN, OP_DONE:
        r.stored = register_site(d.pos_x, d.pos_y, node_id, d.opcode == OP_DONE);
      OP_RX_CLM: if (!own_pkt) begin
        for (i = 0; i < PENDING_DEPTH_DEF; i++)
          if (claims[i].valid && is_near(d.pos_x, d.pos_y, claims[i].x, claims[i].y, claim_r)) begin
            if (d.confidence > claims[i].best_conf) begin
              claims[i].best_conf = d.confidence;
              claims[i].best_id = d.sender_id;
            end else if (d.confidence == claims[i].best_conf && d.sender_id < claims[i].best_id)
              claims[i].best_id = d.sender_id;
          end
      end
      OP_RX_WIN, OP_RX_DONE: if (!own_pkt) begin
        r.stored = register_site(d.pos_x, d.pos_y, d.sender_id, d.opcode == OP_RX_DONE);
        for (i = 0; i < PENDING_DEPTH_DEF; i++)
          if (claims[i].valid && is_near(d.pos_x, d.pos_y, claims[i].x, claims[i].y, claim_r))
            claims[i].valid = 1'b0;
      end
      OP_QUERY: begin
        r.already_claimed = site_near(d.pos_x, d.pos_y, claim_r) >= 0;
        r.in_exclusion = site_near(d.pos_x, d.pos_y, excl_r) >= 0;
      end
      OP_CLEAR: clear_tables();
      default: ;
    endcase
    for (i = 0; i < KNOWN_DEPTH_DEF; i++) if (sites[i].valid) r.known_count++;
    return r;
  endfunction

  task automatic send_request(pct_in_t d);
    int gap;
    bit rdy;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    expected_q.push_back(claim_table_step(d));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    case (idx)
      CFG_OWN_ID: node_id = val[7:0];
      CFG_CLAIM_R: claim_r = val[14:0];
      CFG_EXCL_R: excl_r = val[14:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [7:0] id, logic [14:0] cr, logic [14:0] er);
    write_reg(CFG_OWN_ID, {8'($urandom), id});
    write_reg(CFG_CLAIM_R, {1'($urandom), cr});
    write_reg(CFG_EXCL_R, {1'($urandom), er});
    cfg_valid <= 1'b0;
  endtask

  function automatic pct_in_t make_req(logic [3:0] op, int x, int y, int conf, int snd,
                                       logic [31:0] tag);
    pct_in_t d;
    d.opcode = op;
    d.pos_x = 16'(x);
    d.pos_y = 16'(y);
    d.confidence = 8'(conf);
    d.sender_id = 8'(snd);
    d.claim_tag = tag;
    return d;
  endfunction

  function automatic pct_in_t random_req();
    pct_in_t d;
    int k, pick;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    d = rnd[$bits(pct_in_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 22) d.opcode = OP_CLAIM;
    else if (pick < 40) d.opcode = OP_RESOLVE;
    else if (pick < 47) d.opcode = OP_WIN;
    else if (pick < 52) d.opcode = OP_DONE;
    else if (pick < 68) d.opcode = OP_RX_CLM;
    else if (pick < 74) d.opcode = OP_RX_WIN;
    else if (pick < 78) d.opcode = OP_RX_DONE;
    else if (pick < 95) d.opcode = OP_QUERY;
    else if (pick < 97) d.opcode = OP_CLEAR;
    else d.opcode = 4'(OP_CLEAR + $urandom_range(1, 7));
    if ($urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, 5);
      d.pos_x = cx[k] + 16'($signed($urandom_range(0, 1600)) - 800);
      d.pos_y = cy[k] + 16'($signed($urandom_range(0, 1600)) - 800);
    end
    if ($urandom_range(0, 7) == 0) d.sender_id = node_id;
    if ($urandom_range(0, 3) == 0) d.confidence = claims[$urandom_range(0, 7)].best_conf;
    if (d.opcode == OP_RESOLVE && $urandom_range(0, 9) < 7)
      d.claim_tag = claims[$urandom_range(0, PENDING_DEPTH_DEF - 1)].id;
    else if ($urandom_range(0, 19) == 0) d.claim_tag = '0;
    return d;
  endfunction

  // receiver: random stall per result, long hold-off on request, then compare
  initial begin
    int stall;
    bit vld;
    pct_out_t got, want;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if (stall > 0 || hold_left > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_left > 0) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        vld = out_valid;
        got = out_data;
        @(posedge clk);
      end while (!vld);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got.new_claim_id !== want.new_claim_id || got.won !== want.won ||
            got.stored !== want.stored || got.already_claimed !== want.already_claimed ||
            got.in_exclusion !== want.in_exclusion || got.known_count !== want.known_count) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    int i;
    configure(8'd7, 15'd500, 15'd1000);
    for (i = 0; i < PENDING_DEPTH_DEF + 1; i++)
      send_request(make_req(OP_CLAIM, i * 3000 - 32768, 32767 - i * 3000, 100 + i, 0, 0));
    send_request(make_req(OP_RESOLVE, 0, 0, 0, 0, 32'd0));
    send_request(make_req(OP_RX_CLM, -32768, 32767, 200, 3, 0));
    send_request(make_req(OP_RX_CLM, -32760, 32760, 255, 7, 0));
    send_request(make_req(OP_RX_CLM, -29768, 29767, 101, 2, 0));
    send_request(make_req(OP_RESOLVE, 0, 0, 0, 0, claims[0].id));
    send_request(make_req(OP_RESOLVE, 0, 0, 0, 0, claims[1].id));
    send_request(make_req(OP_RESOLVE, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_request(make_req(OP_RX_WIN, -26768, 26767, 0, 9, 0));
    send_request(make_req(OP_RX_DONE, -26700, 26700, 0, 7, 0));
    send_request(make_req(OP_DONE, 32767, -32768, 0, 0, 0));
    send_request(make_req(OP_WIN, 32767, -32768, 0, 0, 0));
    send_request(make_req(OP_QUERY, 32767, -32300, 0, 0, 0));
    send_request(make_req(OP_QUERY, 32767, -31800, 0, 0, 0));
    send_request(make_req(OP_QUERY, -32768, 32767, 0, 0, 0));
    send_request(make_req(4'd15, 0, 0, 0, 0, 0));
    send_request(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
    for (i = 0; i < KNOWN_DEPTH_DEF + 1; i++)
      send_request(make_req(OP_WIN, i * 3800 - 32768, 0, 0, 0, 0));
    wait_drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_request(random_req());
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_left = 600;
    no_gap = 1;
    for (int i = 0; i < 20; i++) send_request(random_req());
    no_gap = 0;
    wait_drain();
  endtask

  task automatic test_config_sweep();
    configure(8'd255, 15'd0, 15'd32767);
    test_random(200);
    configure(8'd0, 15'd32767, 15'd0);
    test_random(150);
    for (int p = 0; p < 5; p++) begin
      configure(8'($urandom), 15'($urandom_range(50, 3000)), 15'($urandom_range(100, 32767)));
      test_random(220);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_left = 0;
    no_gap = 0;
    mismatches = 0;
    clear_tables();
    seq_q = '0;
    node_id = OWN_ID_RST;
    claim_r = CLAIM_R_RST;
    excl_r = EXCL_R_RST;
    for (int k = 0; k < 6; k++) begin
      cx[k] = 16'($urandom_range(0, 60000) - 30000);
      cy[k] = 16'($urandom_range(0, 60000) - 30000);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_random(150);
    test_directed();
    test_backpressure();
    test_config_sweep();
    test_backpressure();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
